FILE: rtl/pict_pkg.sv
// Shared constants for the point-in-cylinder containment test.
// Field widths, fixed-point shifts, register indexes and reset values.
// No dependencies.
package pict_pkg;

   // Default width of one signed Q8.8 point coordinate.
   localparam int COORD_BITS_DEF = 16;

   // Signed Q2.14 transform coefficients and Q8.8 translations.
   localparam int COEF_BITS = 16;
   localparam int FRAC_SHIFT = 14;

   // Unsigned Q7.8 radius, half height and half shell.
   localparam int DIM_BITS = 15;
   localparam int MODE_BITS = 2;

   localparam int ROW_BITS = 64;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   // Width of a clamped local magnitude, and of its square or the sum of two squares.
   localparam int MAG_BITS = 32;
   localparam int SQ_BITS = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_X       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_Y       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_Z       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_SHELL  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHELL_MODE  = 3'd6;

   // Shell mode codes. Bit one alone selects the capped shell.
   localparam logic [MODE_BITS-1:0] MODE_SOLID  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_OPEN   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CAPPED = 2'd2;

   // Identity transform after reset.
   localparam logic [ROW_BITS-1:0] ROW_X_RST = 64'h4000_0000_0000_0000;
   localparam logic [ROW_BITS-1:0] ROW_Y_RST = 64'h0000_4000_0000_0000;
   localparam logic [ROW_BITS-1:0] ROW_Z_RST = 64'h0000_0000_4000_0000;

endpackage

FILE: rtl/point_in_cylinder_test.sv
// Point-in-cylinder containment test, top level and whole datapath.
// Depends on pict_pkg for widths, register indexes and reset values.
//
// Usage:
//   Input channel: a point (req_pos_x, req_pos_y, req_pos_z, signed Q8.8) is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while reset is applied and in the cycle after it, so the block takes
//   one point in every cycle; points may arrive back to back without gaps.
//   Result channel: rsp_inside_res is valid for exactly one cycle while
//   rsp_strobe is high. Every transfer on the input side produces exactly one
//   result, in order. The receiver cannot hold results off, and the pipeline
//   never stalls: there is no backpressure anywhere.
//   Pipeline: a point passes through six registered stages (products, row
//   sums, magnitude and height tests, squares, radial sum, final compare),
//   and rsp_strobe is high while its result sits in the last. Throughput is
//   one point per cycle, since every stage passes its data on at every edge.
//   Configuration: csr_we, csr_index and csr_wdata write one register per
//   cycle with no wait. Write only while no point is in flight. The derived
//   bounds are registered from these registers in the cycle after a write.
//   Reset: synchronous and active high. It loads the identity transform,
//   clears radius, half height, half shell and mode, and empties the pipeline.
module point_in_cylinder_test #(
   parameter int COORD_BITS = pict_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_pos_z,
   output logic                                 rsp_strobe,
   output logic                                 rsp_inside_res,
   input  logic                                 csr_we,
   input  logic [pict_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pict_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pict_pkg::*;

   // Product of a Q2.14 coefficient and a coordinate, and a local coordinate
   // in Q.22. The local width holds three products plus the scaled
   // translation without overflow, and never drops below the clamp width.
   localparam int PROD_W = COORD_BITS + COEF_BITS;
   localparam int LOC_W = (COORD_BITS + 17 > MAG_BITS) ? COORD_BITS + 17 : MAG_BITS;
   localparam logic [LOC_W-1:0] CLAMP_MAG = LOC_W'(64'd1 << (MAG_BITS - 1));
   localparam int DEPTH = 6;

   // Configuration registers.
   logic [ROW_BITS-1:0]  row_ff [3];
   logic [ROW_BITS-1:0]  row_in [3];
   logic [DIM_BITS-1:0]  radius_ff, radius_in;
   logic [DIM_BITS-1:0]  half_height_ff, half_height_in;
   logic [DIM_BITS-1:0]  half_shell_ff, half_shell_in;
   logic [MODE_BITS-1:0] shell_mode_ff, shell_mode_in;

   // Bounds derived from the configuration, all in the scale of the data.
   logic [SQ_BITS-1:0]      rad2_ff, rad2_in;
   logic [SQ_BITS-1:0]      outer2_ff, outer2_in;
   logic [SQ_BITS-1:0]      inner2_ff, inner2_in;
   logic                    inner_pos_ff, inner_pos_in;
   logic signed [LOC_W-1:0] zs_hi_ff, zs_hi_in, zs_lo_ff, zs_lo_in;
   logic signed [LOC_W-1:0] zo_hi_ff, zo_hi_in, zo_lo_ff, zo_lo_in;
   logic signed [LOC_W-1:0] zc_hi_ff, zc_hi_in, zc_lo_ff, zc_lo_in;

   logic                     xfer;
   logic                     busy_ff, busy_in;
   logic [DEPTH-1:0]         vld_ff, vld_in;

   logic signed [COEF_BITS-1:0]  coef [3][3];
   logic signed [COEF_BITS-1:0]  trans [3];
   logic signed [COORD_BITS-1:0] pos [3];

   // Stage 1: the nine products.
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   // Stage 2: local coordinates.
   logic signed [LOC_W-1:0]  loc_ff [3];
   logic signed [LOC_W-1:0]  loc_in [3];
   // Stage 3: clamped radial magnitudes and height tests.
   logic [LOC_W-1:0]         abs_val [2];
   logic [MAG_BITS-1:0]      mag_ff [2];
   logic [MAG_BITS-1:0]      mag_in [2];
   logic [2:0]               zf3_ff, zf3_in;
   // Stage 4: squares.
   logic [SQ_BITS-1:0]       sq_ff [2];
   logic [SQ_BITS-1:0]       sq_in [2];
   logic [2:0]               zf4_ff;
   // Stage 5: squared radial distance.
   logic [SQ_BITS-1:0]       d2_ff, d2_in;
   logic [2:0]               zf5_ff;
   // Stage 6: the answer.
   logic                     inside_ff, inside_in;

   logic [2*DIM_BITS-1:0]    rad_sq;
   logic [DIM_BITS:0]        outer_sum;
   logic [2*DIM_BITS+1:0]    outer_sq;
   logic [DIM_BITS-1:0]      inner_dif;
   logic [2*DIM_BITS-1:0]    inner_sq;
   logic                     below_inner;
   logic                     z_solid, z_outer, z_core;

   // A point is taken whenever start is high and busy is low; nothing downstream can stall.
   assign xfer = start && !busy_ff;
   assign busy = busy_ff;
   assign rsp_strobe = vld_ff[DEPTH-1];
   assign rsp_inside_res = inside_ff;

   assign busy_in = reset;
   assign vld_in = {vld_ff[DEPTH-2:0], xfer};

   // Register writes. Each register keeps the low bits it is wide.
   always_comb begin
      row_in[0] = row_ff[0];
      row_in[1] = row_ff[1];
      row_in[2] = row_ff[2];
      radius_in = radius_ff;
      half_height_in = half_height_ff;
      half_shell_in = half_shell_ff;
      shell_mode_in = shell_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X:       row_in[0] = csr_wdata;
            CSR_ROW_Y:       row_in[1] = csr_wdata;
            CSR_ROW_Z:       row_in[2] = csr_wdata;
            CSR_RADIUS:      radius_in = csr_wdata[DIM_BITS-1:0];
            CSR_HALF_HEIGHT: half_height_in = csr_wdata[DIM_BITS-1:0];
            CSR_HALF_SHELL:  half_shell_in = csr_wdata[DIM_BITS-1:0];
            CSR_SHELL_MODE:  shell_mode_in = csr_wdata[MODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_X_RST;
         row_ff[1] <= ROW_Y_RST;
         row_ff[2] <= ROW_Z_RST;
         radius_ff <= '0;
         half_height_ff <= '0;
         half_shell_ff <= '0;
         shell_mode_ff <= MODE_SOLID;
         vld_ff <= '0;
      end else begin
         row_ff <= row_in;
         radius_ff <= radius_in;
         half_height_ff <= half_height_in;
         half_shell_ff <= half_shell_in;
         shell_mode_ff <= shell_mode_in;
         vld_ff <= vld_in;
      end
      busy_ff <= busy_in;
   end

   // Derived bounds. Radial bounds are squared in Q.16 and moved to Q.44;
   // height bounds are moved to Q.22. The capped shell's core band is
   // empty when the half shell exceeds the half height.
   always_comb begin
      rad_sq = radius_ff * radius_ff;
      outer_sum = {1'b0, radius_ff} + {1'b0, half_shell_ff};
      outer_sq = outer_sum * outer_sum;
      inner_pos_in = radius_ff > half_shell_ff;
      inner_dif = radius_ff - half_shell_ff;
      inner_sq = inner_dif * inner_dif;
      rad2_in = SQ_BITS'({rad_sq, 28'b0});
      outer2_in = SQ_BITS'({outer_sq, 28'b0});
      inner2_in = SQ_BITS'({inner_sq, 28'b0});
      zs_hi_in = LOC_W'(signed'({2'b00, half_height_ff})) <<< FRAC_SHIFT;
      zs_lo_in = -zs_hi_in;
      zo_hi_in = LOC_W'(signed'({1'b0, {1'b0, half_height_ff} +
                                   {1'b0, half_shell_ff}})) <<< FRAC_SHIFT;
      zo_lo_in = -zo_hi_in;
      zc_hi_in = LOC_W'(signed'({2'b00, half_height_ff}) -
                        signed'({2'b00, half_shell_ff})) <<< FRAC_SHIFT;
      zc_lo_in = -zc_hi_in;
   end

   always_ff @(posedge clock) begin
      rad2_ff <= rad2_in;
      outer2_ff <= outer2_in;
      inner2_ff <= inner2_in;
      inner_pos_ff <= inner_pos_in;
      zs_hi_ff <= zs_hi_in;
      zs_lo_ff <= zs_lo_in;
      zo_hi_ff <= zo_hi_in;
      zo_lo_ff <= zo_lo_in;
      zc_hi_ff <= zc_hi_in;
      zc_lo_ff <= zc_lo_in;
   end

   // Stage 1: unpack the rows and form each coefficient times coordinate.
   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trans[i] = signed'(row_ff[i][COEF_BITS-1:0]);
         for (int j = 0; j < 3; j++) begin
            coef[i][j] = signed'(row_ff[i][ROW_BITS-1-COEF_BITS*j -: COEF_BITS]);
            prod_in[i][j] = PROD_W'(coef[i][j]) * PROD_W'(pos[j]);
         end
      end
   end

   // Stage 2: row sums plus the translation moved to Q.22.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         loc_in[i] = LOC_W'(prod_ff[i][0]) + LOC_W'(prod_ff[i][1]) +
                     LOC_W'(prod_ff[i][2]) + (LOC_W'(trans[i]) <<< FRAC_SHIFT);
      end
   end

   // Stage 3: radial magnitudes, clamped to 2^31 so that the squares fit,
   // and the three height tests on the local z.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         abs_val[i] = loc_ff[i][LOC_W-1] ? (~loc_ff[i] + LOC_W'(1)) : loc_ff[i];
         mag_in[i] = (abs_val[i] > CLAMP_MAG) ? MAG_BITS'(CLAMP_MAG)
                                                : abs_val[i][MAG_BITS-1:0];
      end
      zf3_in[0] = (loc_ff[2] >= zs_lo_ff) && (loc_ff[2] <= zs_hi_ff);
      zf3_in[1] = (loc_ff[2] >= zo_lo_ff) && (loc_ff[2] <= zo_hi_ff);
      zf3_in[2] = (loc_ff[2] > zc_lo_ff) && (loc_ff[2] < zc_hi_ff);
   end

   // Stage 4: squares. Stage 5: their sum.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sq_in[i] = {{(SQ_BITS-MAG_BITS){1'b0}}, mag_ff[i]} *
                    {{(SQ_BITS-MAG_BITS){1'b0}}, mag_ff[i]};
      end
      d2_in = sq_ff[0] + sq_ff[1];
   end

   // Stage 6: the solid test, or the shell test with or without caps.
   assign z_solid = zf5_ff[0];
   assign z_outer = zf5_ff[1];
   assign z_core = zf5_ff[2];
   assign below_inner = inner_pos_ff && (d2_ff < inner2_ff);

   always_comb begin
      if (shell_mode_ff == MODE_SOLID) begin
         inside_in = z_solid && (d2_ff <= rad2_ff);
      end else if ((shell_mode_ff & MODE_CAPPED) != MODE_SOLID) begin
         inside_in = z_outer && (d2_ff <= outer2_ff) && !(z_core && below_inner);
      end else begin
         inside_in = z_outer && (d2_ff <= outer2_ff) && !below_inner;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      loc_ff <= loc_in;
      mag_ff <= mag_in;
      zf3_ff <= zf3_in;
      sq_ff <= sq_in;
      zf4_ff <= zf3_ff;
      d2_ff <= d2_in;
      zf5_ff <= zf4_ff;
      inside_ff <= inside_in;
   end

`ifndef SYNTH
   // Every transfer yields its result strobe at the end of the valid pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##DEPTH rsp_strobe)
      else $error("input transfer without its result strobe");

   // No result appears without a matching earlier transfer.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, DEPTH))
      else $error("result strobe does not follow the input transfer");

   // The block refuses points only around reset.
   a_busy_reset: assert property (@(posedge clock)
      busy |-> $past(reset))
      else $error("busy raised outside reset");

   // An open shell never reports a point inside its inner surface.
   a_open_shell: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-2] && (shell_mode_ff == MODE_OPEN) && below_inner |=> !rsp_inside_res)
      else $error("open shell accepted a point in its hollow");
`endif

endmodule

FILE: dv/pict_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the point-in-cylinder containment test.
// Watches the register port and both handshakes, predicts every answer, compares.
// Depends on pict_pkg for widths, register indexes, mode codes and reset values.
module pict_result_checker #(
   parameter int COORD_BITS = pict_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_pos_z,
   input  logic                                 rsp_strobe,
   input  logic                                 rsp_inside_res,
   input  logic                                 csr_we,
   input  logic [pict_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pict_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                   mismatch_count,
   output int                                   answers_pending
);
   import pict_pkg::*;

   typedef longint unsigned sq_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic                         in_shape;
   } answer_type;

   localparam sq_type MAG_CLAMP = sq_type'(1) << (MAG_BITS - 1);
   localparam int MAX_REPORTS = 40;

   logic [ROW_BITS-1:0]  row_x, row_y, row_z;
   logic [DIM_BITS-1:0]  radius_q, half_height_q, half_shell_q;
   logic [MODE_BITS-1:0] mode_q;
   answer_type           inside_expected [$];

   // Local coordinate in Q.22: Q2.14 coefficients times Q8.8 coordinates,
   // plus the Q8.8 translation lifted by the coefficient fraction.
   function automatic longint local_coord(input logic [ROW_BITS-1:0] row,
                                          input longint px, py, pz);
      longint cx, cy, cz, t;
      cx = longint'($signed(row[63:48]));
      cy = longint'($signed(row[47:32]));
      cz = longint'($signed(row[31:16]));
      t  = longint'($signed(row[15:0]));
      return cx * px + cy * py + cz * pz + t * (longint'(1) << FRAC_SHIFT);
   endfunction

   function automatic sq_type clamped_square(input longint v);
      sq_type m;
      m = (v < 0) ? sq_type'(-v) : sq_type'(v);
      if (m > MAG_CLAMP)
         m = MAG_CLAMP;
      return m * m;
   endfunction

   function automatic logic contains_point(input longint px, py, pz);
      longint lx, ly, lz, r, hh, hs, outer, inner;
      sq_type d2;
      logic   below_inner, in_shape;
      lx = local_coord(row_x, px, py, pz);
      ly = local_coord(row_y, px, py, pz);
      lz = local_coord(row_z, px, py, pz);
      d2 = clamped_square(lx) + clamped_square(ly);
      r  = longint'(radius_q) << FRAC_SHIFT;
      hh = longint'(half_height_q) << FRAC_SHIFT;
      hs = longint'(half_shell_q) << FRAC_SHIFT;
      if (mode_q == MODE_SOLID) begin
         return (lz >= -hh) && (lz <= hh) && (d2 <= sq_type'(r) * sq_type'(r));
      end
      outer = r + hs;
      inner = r - hs;
      below_inner = (inner > 0) && (d2 < sq_type'(inner) * sq_type'(inner));
      in_shape = 1'b1;
      if (lz < -hh - hs || lz > hh + hs)
         in_shape = 1'b0;
      else if (d2 > sq_type'(outer) * sq_type'(outer))
         in_shape = 1'b0;
      else if ((mode_q & MODE_CAPPED) != '0) begin
         // Capped shell: only the hollow core between the caps is excluded.
         if (lz > -hh + hs && lz < hh - hs && below_inner)
            in_shape = 1'b0;
      end else if (below_inner) begin
         in_shape = 1'b0;
      end
      return in_shape;
   endfunction

   // Counts every mismatch; the printout stops after a few dozen lines.
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      answers_pending = 0;
   end

   always @(posedge clock) begin
      answer_type head;
      if (reset) begin
         row_x = ROW_X_RST;
         row_y = ROW_Y_RST;
         row_z = ROW_Z_RST;
         radius_q = '0;
         half_height_q = '0;
         half_shell_q = '0;
         mode_q = MODE_SOLID;
         inside_expected.delete();
      end else begin
         if (start === 1'b1 && busy === 1'b0) begin
            head.x = req_pos_x;
            head.y = req_pos_y;
            head.z = req_pos_z;
            head.in_shape = contains_point(longint'(req_pos_x), longint'(req_pos_y),
                                           longint'(req_pos_z));
            inside_expected.push_back(head);
         end
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_ROW_X:       row_x = csr_wdata;
               CSR_ROW_Y:       row_y = csr_wdata;
               CSR_ROW_Z:       row_z = csr_wdata;
               CSR_RADIUS:      radius_q = csr_wdata[DIM_BITS-1:0];
               CSR_HALF_HEIGHT: half_height_q = csr_wdata[DIM_BITS-1:0];
               CSR_HALF_SHELL:  half_shell_q = csr_wdata[DIM_BITS-1:0];
               CSR_SHELL_MODE:  mode_q = csr_wdata[MODE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_strobe === 1'b1) begin
            if (inside_expected.size() == 0) begin
               report_mismatch("result strobe with no point in flight");
            end else begin
               head = inside_expected.pop_front();
               if (rsp_inside_res !== head.in_shape)
                  report_mismatch($sformatf("point (%0d, %0d, %0d): inside %b, expected %b",
                                            head.x, head.y, head.z, rsp_inside_res,
                                            head.in_shape));
            end
         end
      end
      answers_pending = inside_expected.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top level of the point-in-cylinder containment test bench: clock, reset,
// register setups and point stimulus. Depends on pict_pkg, the block and pict_result_checker.
module testbench;
   import pict_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   // Drain time for the pipeline after the last answer, with a little margin on top.
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1900;
   // The last 300 random points get no random gaps between transfers.
   localparam int QUIET_ITEMS = 300;
   localparam logic [MODE_BITS-1:0] MODE_CAPPED_ALIAS = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [15:0] coef_type;
   typedef enum int {XF_IDENTITY, XF_AXIS_SWAP, XF_SKEWED, XF_ARBITRARY} xform_kind_type;

   localparam coef_type UNITY = 16'sh4000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   coord_type                req_pos_x, req_pos_y, req_pos_z;
   logic                     rsp_strobe;
   logic                     rsp_inside_res;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                       mismatch_count;
   int                       answers_pending;

   // Stimulus state shared by the helper tasks below.
   int                       items_sent;
   int                       point_span;
   bit                       idle_on;

   point_in_cylinder_test #(.COORD_BITS(COORD_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .rsp_strobe     (rsp_strobe),
      .rsp_inside_res (rsp_inside_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   pict_result_checker #(.COORD_BITS(COORD_BITS)) result_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_strobe      (rsp_strobe),
      .rsp_inside_res  (rsp_inside_res),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A hung pipeline or lost answers end the run here. The slowest legal run
   // is well under a tenth of this.
   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Presents one point at the falling edge and holds it until the transfer
   // happens. It returns at the next falling edge with start still high, so a
   // following point goes out back to back.
   task automatic send_point(input coord_type x, input coord_type y, input coord_type z);
      req_pos_x = x;
      req_pos_y = y;
      req_pos_z = z;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Random gaps between transfers, so that idle cycles land on every stage
   // of the pipeline. The closing stretch of the run has none.
   task automatic maybe_idle();
      if (idle_on && items_sent < RANDOM_ITEMS - QUIET_ITEMS &&
          $urandom_range(0, 4) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_we = 1'b1;
      @(negedge clock);
   endtask

   // Waits until every answer is back and the pipeline has run dry, then
   // writes all seven registers. Half the time the unused upper bits of the
   // narrow registers carry junk, which the block has to drop.
   task automatic load_cylinder(input logic [ROW_BITS-1:0] rx, ry, rz,
                                input logic [DIM_BITS-1:0] rad, hgt, shl,
                                input logic [MODE_BITS-1:0] mode);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      start = 1'b0;
      wait (answers_pending == 0);
      @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_ROW_X, rx);
      write_reg(CSR_ROW_Y, ry);
      write_reg(CSR_ROW_Z, rz);
      write_reg(CSR_RADIUS, (junk & ~64'h7FFF) | CSR_DATA_BITS'(rad));
      write_reg(CSR_HALF_HEIGHT, (junk & ~64'h7FFF) | CSR_DATA_BITS'(hgt));
      write_reg(CSR_HALF_SHELL, (junk & ~64'h7FFF) | CSR_DATA_BITS'(shl));
      write_reg(CSR_SHELL_MODE, (junk & ~64'h3) | CSR_DATA_BITS'(mode));
      // A write to the unused index must leave every register alone.
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_UNUSED, {$urandom, $urandom});
      csr_we = 1'b0;
   endtask

   // Dimensions lean toward a few units so that points often land inside,
   // with zero and full scale thrown in now and then.
   function automatic logic [DIM_BITS-1:0] pick_dim();
      case ($urandom_range(0, 9)) inside
         0:       return '0;
         1:       return '1;
         2, 3:    return DIM_BITS'($urandom_range(0, 32767));
         default: return DIM_BITS'($urandom_range(0, 2048));
      endcase
   endfunction

   function automatic coef_type small_offset();
      return coef_type'(int'($urandom_range(0, 512)) - 256);
   endfunction

   // Most coordinates fall within reach of the cylinder; some cover the
   // whole signed range.
   function automatic coord_type random_coord();
      if ($urandom_range(0, 19) < 3)
         return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 2 * point_span)) - point_span);
   endfunction

   // One random setup: a transform of some kind, dimensions and a mode
   // (mode three included). The point spread follows the cylinder's size.
   task automatic random_cylinder();
      xform_kind_type      kind;
      logic [ROW_BITS-1:0] rows [3];
      coef_type            c [3];
      coef_type            t;
      logic [DIM_BITS-1:0] rad, hgt, shl;
      int                  reach;
      kind = xform_kind_type'($urandom_range(0, 3));
      for (int i = 0; i < 3; i++) begin
         c[0] = '0;
         c[1] = '0;
         c[2] = '0;
         t = small_offset();
         case (kind)
            XF_IDENTITY:
               c[i] = UNITY;
            XF_AXIS_SWAP:
               c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? UNITY : -UNITY;
            XF_SKEWED: begin
               for (int j = 0; j < 3; j++)
                  c[j] = coef_type'((j == i ? int'(UNITY) : 0) +
                                    int'($urandom_range(0, 4096)) - 2048);
            end
            default: begin
               c[0] = coef_type'($urandom);
               c[1] = coef_type'($urandom);
               c[2] = coef_type'($urandom);
               t = coef_type'($urandom);
            end
         endcase
         rows[i] = {c[0], c[1], c[2], t};
      end
      rad = pick_dim();
      hgt = pick_dim();
      shl = pick_dim();
      load_cylinder(rows[0], rows[1], rows[2], rad, hgt, shl,
                    MODE_BITS'($urandom_range(0, 3)));
      reach = (int'(rad) + int'(hgt) + int'(shl)) * 5 / 4 + 384;
      if (kind == XF_ARBITRARY || reach > 32767)
         reach = 32767;
      point_span = reach;
   endtask

   initial begin
      int phase_len;
      reset = 1'b1;
      start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      csr_we = 1'b0;
      csr_index = CSR_ROW_X;
      csr_wdata = '0;
      items_sent = 0;
      point_span = 32767;
      idle_on = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Reset setup: identity transform and zero size, so only the origin
      // itself counts as inside.
      send_point(0, 0, 0);                      maybe_idle();
      send_point(1, 0, 0);                      maybe_idle();
      send_point(0, 0, -1);                     maybe_idle();
      send_point(32767, -32768, 32767);         maybe_idle();
      send_point(-32768, -32768, -32768);       maybe_idle();

      // Solid cylinder of radius one and height four, probed on its surface
      // and one step beyond it.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd256, 15'd512, 15'd0, MODE_SOLID);
      send_point(256, 0, 0);                    maybe_idle();
      send_point(257, 0, 0);                    maybe_idle();
      send_point(0, -256, -512);                maybe_idle();
      send_point(0, 0, 513);                    maybe_idle();
      send_point(181, -181, 0);                 maybe_idle();
      send_point(182, 182, 0);                  maybe_idle();

      // Open shell: the axis is hollow, the inner and outer surfaces and the
      // rim at the end belong to the shell.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd1024, 15'd512, 15'd128, MODE_OPEN);
      send_point(0, 0, 0);                      maybe_idle();
      send_point(896, 0, 0);                    maybe_idle();
      send_point(895, 0, 0);                    maybe_idle();
      send_point(0, -1100, 640);                maybe_idle();

      // Capped shell: the end caps are solid, the core between them is not.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd1024, 15'd512, 15'd128,
                    MODE_CAPPED);
      send_point(0, 0, 0);                      maybe_idle();
      send_point(0, 0, 384);                    maybe_idle();
      send_point(0, 0, -383);                   maybe_idle();

      // Mode three has the capped shell's behavior.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd1024, 15'd512, 15'd128,
                    MODE_CAPPED_ALIAS);
      send_point(0, 0, 384);                    maybe_idle();

      // A shell thicker than the radius has no hollow core at all.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd100, 15'd512, 15'd200, MODE_OPEN);
      send_point(0, 0, 0);                      maybe_idle();

      // A shell of zero thickness is only the mantle surface itself.
      load_cylinder(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 15'd1024, 15'd512, 15'd0, MODE_OPEN);
      send_point(1024, 0, 0);                   maybe_idle();
      send_point(0, 1023, 0);                   maybe_idle();

      // Full-scale coefficients push the local x and y past the clamp for
      // the corner points, while the origin maps within the widest shell.
      load_cylinder(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0,
                    15'h7FFF, 15'h7FFF, 15'h7FFF, MODE_OPEN);
      send_point(-32768, -32768, -32768);       maybe_idle();
      send_point(32767, 32767, 32767);          maybe_idle();
      send_point(0, 0, 0);                      maybe_idle();

      // Random phases, each with a fresh setup. Some phases run without any
      // idling so that long back-to-back stretches occur throughout.
      while (items_sent < RANDOM_ITEMS) begin
         random_cylinder();
         idle_on = $urandom_range(0, 3) != 0;
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            send_point(random_coord(), random_coord(), random_coord());
            items_sent++;
            maybe_idle();
         end
      end

      start = 1'b0;
      wait (answers_pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
